### hdl/assert_macros.svh
// assertion helpers used by the datapath rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, checked outside reset
`define CHK_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication in the next cycle, checked outside reset
`define CHK_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/wcsr_pkg.sv
`default_nettype none
package wcsr_pkg;
   localparam int FEATURES      = 64;
   localparam int FEAT_W        = 6;
   localparam int MAX_POSITIVES = 64;
   localparam int POS_W         = 6;
   localparam int MAX_NEGATIVES = 256;
   localparam int NEG_W         = 8;
   localparam int PCNT_W        = 7;
   localparam int NCNT_W        = 9;
   localparam int ALPHA_W       = 4;
   localparam int DIV_W         = 41;
   localparam int DIVISOR_W     = 9;

   localparam logic [ALPHA_W-1:0] ALPHA_SCALE = 4'd10;
   localparam logic [ALPHA_W-1:0] ALPHA_RESET = 4'd5;

   // request opcodes
   localparam logic [1:0] OP_WR_POS  = 2'd0;
   localparam logic [1:0] OP_WR_NEG  = 2'd1;
   localparam logic [1:0] OP_ROUND   = 2'd2;
   localparam logic [1:0] OP_RESTART = 2'd3;

   // divider operand select
   localparam logic [1:0] DSRC_POS = 2'd0;
   localparam logic [1:0] DSRC_NEG = 2'd1;
   localparam logic [1:0] DSRC_THR = 2'd2;

   typedef struct packed {
      logic       do_write;
      logic       do_restart;
      logic       round_init;
      logic       sweep_start;
      logic       sweep_neg;
      logic       sweep_count;
      logic       div_start;
      logic [1:0] div_src;
      logic       latch_pm;
      logic       latch_nm;
      logic       blend;
      logic       latch_thr;
      logic       latch_ppass;
      logic       best_update;
      logic       next_feature;
      logic       finish;
   } ctl_cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic div_done;
      logic in_pool;
      logic last_feature;
   } dp_status_type;
endpackage
`default_nettype wire

### hdl/weak_classifier_selection_round.sv
// channel   | ports                                  | handshake
// request   | req_opcode .. req_negative_count       | start high, busy low
// response  | rsp_found .. rsp_selected_total        | rsp_valid one-cycle strobe
// config    | csr_wr_data                            | csr_wr_en, no wait
//
// value writes and restart are done without leaving idle; busy stays low.
// a round walks every pooled feature: per feature it runs the sample
// sweeps, two 41-step mean divisions and a 5-step divide by ten; features
// out of the pool are skipped.
// reset is synchronous and needs no clearing pass; the value stores hold
// whatever was written. results cannot be stalled.
`default_nettype none
module weak_classifier_selection_round (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [1:0]                   req_opcode,
   input  wire logic [7:0]                   req_sample_index,
   input  wire logic [wcsr_pkg::FEAT_W-1:0]  req_feature_index,
   input  wire logic signed [31:0]           req_feature_value,
   input  wire logic [wcsr_pkg::PCNT_W-1:0]  req_positive_count,
   input  wire logic [wcsr_pkg::NCNT_W-1:0]  req_negative_count,
   input  wire logic                         csr_wr_en,
   input  wire logic [wcsr_pkg::ALPHA_W-1:0] csr_wr_data,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [wcsr_pkg::FEAT_W-1:0]       rsp_chosen_feature,
   output logic signed [31:0]                rsp_chosen_threshold,
   output logic                              rsp_polarity_positive,
   output logic [wcsr_pkg::NCNT_W-1:0]       rsp_false_pass_count,
   output logic [wcsr_pkg::ALPHA_W-1:0]      rsp_alpha_now,
   output logic [wcsr_pkg::PCNT_W-1:0]       rsp_selected_total
);
   import wcsr_pkg::*;

   ctl_cmd_type   cmd;
   dp_status_type status;

   // round sequencer
   wcsr_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_opcode),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   // stores, sweeps, divider and selection
   wcsr_dp u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_opcode            (req_opcode),
      .req_sample_index      (req_sample_index),
      .req_feature_index     (req_feature_index),
      .req_feature_value     (req_feature_value),
      .req_positive_count    (req_positive_count),
      .req_negative_count    (req_negative_count),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .rsp_valid             (rsp_valid),
      .rsp_found             (rsp_found),
      .rsp_chosen_feature    (rsp_chosen_feature),
      .rsp_chosen_threshold  (rsp_chosen_threshold),
      .rsp_polarity_positive (rsp_polarity_positive),
      .rsp_false_pass_count  (rsp_false_pass_count),
      .rsp_alpha_now         (rsp_alpha_now),
      .rsp_selected_total    (rsp_selected_total)
   );
endmodule
`default_nettype wire

### hdl/wcsr_ram.sv
`default_nettype none
module wcsr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### hdl/wcsr_div.sv
`default_nettype none
module wcsr_div (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [wcsr_pkg::DIV_W-1:0] dividend,
   input  wire logic [wcsr_pkg::DIVISOR_W-1:0]    divisor,
   output logic                                   done,
   output logic signed [31:0]                     quotient
);
   import wcsr_pkg::*;

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W:0]   rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff, dsr_in;
   logic                 neg_ff, neg_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   rem_sh;
   logic [DIV_W-1:0]     quo_signed;

   // restoring division on magnitudes, one quotient bit per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[DIVISOR_W-1:0], quo_ff[DIV_W-1]};
      if (start) begin
         neg_in  = dividend[DIV_W-1];
         quo_in  = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in    = rem_sh - {1'b0, dsr_ff};
            quo_in[0] = 1'b1;
         end else begin
            rem_in = rem_sh;
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
   end

   // sign fix, zero divisor gives zero
   assign quo_signed = neg_ff ? (~quo_ff + 1'b1) : quo_ff;
   assign done       = done_ff;
   assign quotient   = (dsr_ff == '0) ? 32'sd0 : $signed(quo_signed[31:0]);
endmodule

module wcsr_div10 (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   input  wire logic signed [wcsr_pkg::DIV_W-1:0] dividend,
   output logic                                   done,
   output logic signed [31:0]                     quotient
);
   import wcsr_pkg::*;

   localparam logic [2:0] STEPS = 3'd5;

   logic [39:0] mag_ff, mag_in;
   logic [31:0] quo_ff, quo_in;
   logic [3:0]  rem_ff, rem_in;
   logic        neg_ff, neg_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [11:0] rem_sh;
   logic [23:0] prod;
   logic [7:0]  digit;
   logic [39:0] mag_full;

   // one byte per cycle, quotient digit by reciprocal multiply
   assign rem_sh   = {rem_ff, mag_ff[39:32]};
   assign prod     = {12'd0, rem_sh} * 24'd6554;
   assign digit    = prod[23:16];
   assign mag_full = 40'(dividend[DIV_W-1] ? -dividend : dividend);

   always_comb begin
      mag_in  = mag_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         mag_in  = mag_full;
         quo_in  = '0;
         rem_in  = '0;
         neg_in  = dividend[DIV_W-1];
         cnt_in  = STEPS;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         mag_in = {mag_ff[31:0], 8'd0};
         quo_in = {quo_ff[23:0], digit};
         // remainder below ten, so the low four bits carry it
         rem_in = rem_sh[3:0] - {digit[0], 3'b000} - {digit[2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == 3'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mag_ff <= mag_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   // sign fix, truncation toward zero
   assign done     = done_ff;
   assign quotient = neg_ff ? $signed(~quo_ff + 32'd1) : $signed(quo_ff);
endmodule
`default_nettype wire

### hdl/wcsr_ctrl.sv
`default_nettype none
module wcsr_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    start,
   input  wire logic [1:0]              opcode,
   input  wire wcsr_pkg::dp_status_type status,
   output wcsr_pkg::ctl_cmd_type        cmd,
   output logic                         busy
);
   import wcsr_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_FEAT  = 4'd1;
   localparam logic [3:0] S_PSUM  = 4'd2;
   localparam logic [3:0] S_PDIV  = 4'd3;
   localparam logic [3:0] S_NSUM  = 4'd4;
   localparam logic [3:0] S_NDIV  = 4'd5;
   localparam logic [3:0] S_BLEND = 4'd6;
   localparam logic [3:0] S_TDIVS = 4'd7;
   localparam logic [3:0] S_TDIV  = 4'd8;
   localparam logic [3:0] S_PCNT  = 4'd9;
   localparam logic [3:0] S_NCNT  = 4'd10;
   localparam logic [3:0] S_NEXT  = 4'd11;

   logic [3:0] state_ff, state_in;

   // request decode in idle and sequencing of one round, feature by feature
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.do_write   = (opcode == OP_WR_POS) || (opcode == OP_WR_NEG);
               cmd.do_restart = (opcode == OP_RESTART);
               if (opcode == OP_ROUND) begin
                  cmd.round_init = 1'b1;
                  state_in       = S_FEAT;
               end
            end
         end
         S_FEAT: begin
            if (status.in_pool) begin
               cmd.sweep_start = 1'b1;
               state_in        = S_PSUM;
            end else begin
               state_in = S_NEXT;
            end
         end
         S_PSUM: begin
            if (status.sweep_done) begin
               cmd.div_start = 1'b1;
               cmd.div_src   = DSRC_POS;
               state_in      = S_PDIV;
            end
         end
         S_PDIV: begin
            if (status.div_done) begin
               cmd.latch_pm    = 1'b1;
               cmd.sweep_start = 1'b1;
               cmd.sweep_neg   = 1'b1;
               state_in        = S_NSUM;
            end
         end
         S_NSUM: begin
            if (status.sweep_done) begin
               cmd.div_start = 1'b1;
               cmd.div_src   = DSRC_NEG;
               state_in      = S_NDIV;
            end
         end
         S_NDIV: begin
            if (status.div_done) begin
               cmd.latch_nm = 1'b1;
               state_in     = S_BLEND;
            end
         end
         S_BLEND: begin
            cmd.blend = 1'b1;
            state_in  = S_TDIVS;
         end
         S_TDIVS: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DSRC_THR;
            state_in      = S_TDIV;
         end
         S_TDIV: begin
            if (status.div_done) begin
               cmd.latch_thr   = 1'b1;
               cmd.sweep_start = 1'b1;
               cmd.sweep_count = 1'b1;
               state_in        = S_PCNT;
            end
         end
         S_PCNT: begin
            if (status.sweep_done) begin
               cmd.latch_ppass = 1'b1;
               cmd.sweep_start = 1'b1;
               cmd.sweep_count = 1'b1;
               cmd.sweep_neg   = 1'b1;
               state_in        = S_NCNT;
            end
         end
         S_NCNT: begin
            if (status.sweep_done) begin
               cmd.best_update = 1'b1;
               state_in        = S_NEXT;
            end
         end
         S_NEXT: begin
            if (status.last_feature) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end else begin
               cmd.next_feature = 1'b1;
               state_in         = S_FEAT;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
endmodule
`default_nettype wire

### hdl/wcsr_dp.sv
`default_nettype none
`include "assert_macros.svh"
module wcsr_dp (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire wcsr_pkg::ctl_cmd_type         cmd,
   output wcsr_pkg::dp_status_type            status,
   input  wire logic [1:0]                    req_opcode,
   input  wire logic [7:0]                    req_sample_index,
   input  wire logic [wcsr_pkg::FEAT_W-1:0]   req_feature_index,
   input  wire logic signed [31:0]            req_feature_value,
   input  wire logic [wcsr_pkg::PCNT_W-1:0]   req_positive_count,
   input  wire logic [wcsr_pkg::NCNT_W-1:0]   req_negative_count,
   input  wire logic                          csr_wr_en,
   input  wire logic [wcsr_pkg::ALPHA_W-1:0]  csr_wr_data,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic [wcsr_pkg::FEAT_W-1:0]        rsp_chosen_feature,
   output logic signed [31:0]                 rsp_chosen_threshold,
   output logic                               rsp_polarity_positive,
   output logic [wcsr_pkg::NCNT_W-1:0]        rsp_false_pass_count,
   output logic [wcsr_pkg::ALPHA_W-1:0]       rsp_alpha_now,
   output logic [wcsr_pkg::PCNT_W-1:0]        rsp_selected_total
);
   import wcsr_pkg::*;

   // config and round state
   logic [ALPHA_W-1:0]  init_alpha_ff;
   logic [ALPHA_W-1:0]  alpha_ff, alpha_in;
   logic [FEATURES-1:0] pool_ff, pool_in;
   logic [PCNT_W-1:0]   sel_cnt_ff, sel_cnt_in;
   logic [PCNT_W-1:0]   pc_ff;
   logic [NCNT_W-1:0]   nc_ff;
   logic [FEAT_W-1:0]   feat_ff;

   // sweep engine
   logic                sw_active_ff;
   logic                sw_neg_ff;
   logic                sw_count_ff;
   logic [NCNT_W-1:0]   sw_issue_ff;
   logic                rd_valid_ff;
   logic [NCNT_W-1:0]   sw_limit;
   logic                sw_issue;
   logic                sw_done;
   logic signed [DIV_W-1:0] sum_ff;
   logic [NCNT_W-1:0]   pass_ff;
   logic signed [31:0]  rd_value;
   logic                rd_pass;

   // per-feature figures
   logic signed [31:0]      pm_ff, nm_ff, thr_ff;
   logic                    pol_ff;
   logic signed [DIV_W-1:0] numer_ff;
   logic [NCNT_W-1:0]       ppass_ff;

   // best candidate
   logic                    best_found_ff;
   logic [FEAT_W-1:0]       best_feat_ff;
   logic signed [31:0]      best_thr_ff;
   logic                    best_pol_ff;
   logic [NCNT_W-1:0]       best_neg_ff;

   // divider hookup
   logic signed [DIV_W-1:0] div_dividend;
   logic [DIVISOR_W-1:0]    div_divisor;
   logic                    div_start;
   logic                    div_done;
   logic signed [31:0]      div_quo;
   logic                    d10_start;
   logic                    d10_done;
   logic signed [31:0]      d10_quo;

   // memories
   logic                    pos_we, neg_we;
   logic [POS_W+FEAT_W-1:0] pos_waddr, pos_raddr;
   logic [NEG_W+FEAT_W-1:0] neg_waddr, neg_raddr;
   logic [31:0]             pos_rdata, neg_rdata;

   logic [ALPHA_W-1:0]      alpha_comp;
   logic signed [36:0]      term_neg, term_pos;
   logic signed [36:0]      blend_sum;
   logic                    qualify;

   // value stores
   assign pos_we    = cmd.do_write && (req_opcode == OP_WR_POS)
                      && (req_sample_index[7:POS_W] == '0);
   assign neg_we    = cmd.do_write && (req_opcode == OP_WR_NEG);
   assign pos_waddr = {req_sample_index[POS_W-1:0], req_feature_index};
   assign neg_waddr = {req_sample_index[NEG_W-1:0], req_feature_index};
   assign pos_raddr = {sw_issue_ff[POS_W-1:0], feat_ff};
   assign neg_raddr = {sw_issue_ff[NEG_W-1:0], feat_ff};

   wcsr_ram #(.WIDTH(32), .DEPTH(MAX_POSITIVES * FEATURES)) u_pos_ram (
      .clock   (clock),
      .wr_en   (pos_we),
      .wr_addr (pos_waddr),
      .wr_data (req_feature_value),
      .rd_addr (pos_raddr),
      .rd_data (pos_rdata)
   );

   wcsr_ram #(.WIDTH(32), .DEPTH(MAX_NEGATIVES * FEATURES)) u_neg_ram (
      .clock   (clock),
      .wr_en   (neg_we),
      .wr_addr (neg_waddr),
      .wr_data (req_feature_value),
      .rd_addr (neg_raddr),
      .rd_data (neg_rdata)
   );

   // sweep over samples of the current feature
   assign sw_limit = sw_neg_ff ? nc_ff : {2'b00, pc_ff};
   assign sw_issue = sw_active_ff && (sw_issue_ff != sw_limit);
   assign sw_done  = sw_active_ff && (sw_issue_ff == sw_limit) && !rd_valid_ff;
   assign rd_value = $signed(sw_neg_ff ? neg_rdata : pos_rdata);
   assign rd_pass  = pol_ff ? (rd_value > thr_ff) : (rd_value < thr_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         sw_active_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (cmd.sweep_start) begin
            sw_active_ff <= 1'b1;
         end else if (sw_done) begin
            sw_active_ff <= 1'b0;
         end
         rd_valid_ff <= sw_issue;
      end
      if (cmd.sweep_start) begin
         sw_issue_ff <= '0;
         sw_neg_ff   <= cmd.sweep_neg;
         sw_count_ff <= cmd.sweep_count;
         sum_ff      <= '0;
         pass_ff     <= '0;
      end else begin
         if (sw_issue) begin
            sw_issue_ff <= sw_issue_ff + 1'b1;
         end
         if (rd_valid_ff) begin
            if (sw_count_ff) begin
               pass_ff <= pass_ff + NCNT_W'(rd_pass);
            end else begin
               sum_ff <= sum_ff + DIV_W'(rd_value);
            end
         end
      end
   end

   // divider operand select, means use the sample count
   always_comb begin
      case (cmd.div_src)
         DSRC_POS: begin
            div_dividend = sum_ff;
            div_divisor  = {2'b00, pc_ff};
         end
         DSRC_NEG: begin
            div_dividend = sum_ff;
            div_divisor  = nc_ff;
         end
         default: begin
            div_dividend = sum_ff;
            div_divisor  = '0;
         end
      endcase
   end

   assign div_start = cmd.div_start && (cmd.div_src != DSRC_THR);
   assign d10_start = cmd.div_start && (cmd.div_src == DSRC_THR);

   wcsr_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   // threshold divide by the alpha scale
   wcsr_div10 u_div10 (
      .clock    (clock),
      .reset    (reset),
      .start    (d10_start),
      .dividend (numer_ff),
      .done     (d10_done),
      .quotient (d10_quo)
   );

   // threshold blend numerator
   assign alpha_comp = ALPHA_SCALE - alpha_ff;
   assign term_neg   = $signed({1'b0, alpha_comp}) * nm_ff;
   assign term_pos   = $signed({1'b0, alpha_ff}) * pm_ff;
   assign blend_sum  = term_neg + term_pos;
   assign qualify    = (ppass_ff == {2'b00, pc_ff});

   always_ff @(posedge clock) begin
      if (cmd.latch_pm) begin
         pm_ff <= div_quo;
      end
      if (cmd.latch_nm) begin
         nm_ff <= div_quo;
      end
      if (cmd.blend) begin
         numer_ff <= DIV_W'(blend_sum);
         pol_ff   <= (pm_ff > nm_ff);
      end
      if (cmd.latch_thr) begin
         thr_ff <= d10_quo;
      end
      if (cmd.latch_ppass) begin
         ppass_ff <= pass_ff;
      end
   end

   // round setup, feature walk and best tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         best_found_ff <= 1'b0;
      end else if (cmd.round_init) begin
         best_found_ff <= 1'b0;
      end else if (cmd.best_update && qualify
                   && (!best_found_ff || (pass_ff < best_neg_ff))) begin
         best_found_ff <= 1'b1;
      end
      if (cmd.round_init) begin
         pc_ff   <= (req_positive_count > PCNT_W'(MAX_POSITIVES))
                    ? PCNT_W'(MAX_POSITIVES) : req_positive_count;
         nc_ff   <= (req_negative_count > NCNT_W'(MAX_NEGATIVES))
                    ? NCNT_W'(MAX_NEGATIVES) : req_negative_count;
         feat_ff <= '0;
      end else if (cmd.next_feature) begin
         feat_ff <= feat_ff + 1'b1;
      end
      if (cmd.best_update && qualify && (!best_found_ff || (pass_ff < best_neg_ff))) begin
         best_feat_ff <= feat_ff;
         best_thr_ff  <= thr_ff;
         best_pol_ff  <= pol_ff;
         best_neg_ff  <= pass_ff;
      end
   end

   // pool, alpha and selection count updates
   always_comb begin
      pool_in    = pool_ff;
      alpha_in   = alpha_ff;
      sel_cnt_in = sel_cnt_ff;
      if (cmd.do_restart) begin
         pool_in    = '1;
         alpha_in   = (init_alpha_ff > ALPHA_SCALE) ? ALPHA_SCALE : init_alpha_ff;
         sel_cnt_in = '0;
      end else if (cmd.finish) begin
         if (best_found_ff) begin
            pool_in[best_feat_ff] = 1'b0;
            if (sel_cnt_ff != '1) begin
               sel_cnt_in = sel_cnt_ff + 1'b1;
            end
         end else if (alpha_ff != '0) begin
            alpha_in = alpha_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_alpha_ff <= ALPHA_RESET;
         alpha_ff      <= ALPHA_RESET;
         pool_ff       <= '1;
         sel_cnt_ff    <= '0;
         rsp_valid     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            init_alpha_ff <= csr_wr_data;
         end
         alpha_ff   <= alpha_in;
         pool_ff    <= pool_in;
         sel_cnt_ff <= sel_cnt_in;
         rsp_valid  <= cmd.finish;
      end
      if (cmd.finish) begin
         rsp_found             <= best_found_ff;
         rsp_chosen_feature    <= best_found_ff ? best_feat_ff : '0;
         rsp_chosen_threshold  <= best_found_ff ? best_thr_ff : 32'sd0;
         rsp_polarity_positive <= best_found_ff && best_pol_ff;
         rsp_false_pass_count  <= best_found_ff ? best_neg_ff : '0;
         rsp_alpha_now         <= alpha_in;
         rsp_selected_total    <= sel_cnt_in;
      end
   end

   assign status.sweep_done   = sw_done;
   assign status.div_done     = div_done || d10_done;
   assign status.in_pool      = pool_ff[feat_ff];
   assign status.last_feature = (feat_ff == FEAT_W'(FEATURES - 1));

   `CHK_NEXT(a_rsp_one_cycle, rsp_valid, !rsp_valid, "result strobe held")
   `CHK_SAME(a_alpha_range, rsp_valid, rsp_alpha_now <= ALPHA_SCALE, "alpha out of range")
   `CHK_SAME(a_none_zero, rsp_valid && !rsp_found,
             (rsp_chosen_feature == '0) && (rsp_false_pass_count == '0), "empty result not zero")
   `CHK_SAME(a_pass_bound, rsp_valid, rsp_false_pass_count <= nc_ff, "pass count above count")
endmodule
`default_nettype wire

### tb/sv/tb_weak_classifier_selection_round.sv
`default_nettype none
module tb_weak_classifier_selection_round;
   timeunit 1ns;
   timeprecision 1ps;
   import wcsr_pkg::*;

   localparam int STALL_LIMIT = 40000;
   localparam int DRAIN_CYCLES = 30;

   typedef struct {
      logic              found;
      logic [FEAT_W-1:0] feature;
      logic [31:0]       threshold;
      logic              polarity;
      logic [NCNT_W-1:0] false_pass;
      logic [ALPHA_W-1:0] alpha;
      logic [PCNT_W-1:0] total;
   } selection_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_opcode = OP_WR_POS;
   logic [7:0] req_sample_index = '0;
   logic [FEAT_W-1:0] req_feature_index = '0;
   logic signed [31:0] req_feature_value = '0;
   logic [PCNT_W-1:0] req_positive_count = '0;
   logic [NCNT_W-1:0] req_negative_count = '0;
   logic csr_wr_en = 1'b0;
   logic [ALPHA_W-1:0] csr_wr_data = '0;
   logic rsp_valid;
   logic rsp_found;
   logic [FEAT_W-1:0] rsp_chosen_feature;
   logic signed [31:0] rsp_chosen_threshold;
   logic rsp_polarity_positive;
   logic [NCNT_W-1:0] rsp_false_pass_count;
   logic [ALPHA_W-1:0] rsp_alpha_now;
   logic [PCNT_W-1:0] rsp_selected_total;

   // predictor state
   logic [31:0] pos_store [MAX_POSITIVES*FEATURES];
   logic [31:0] neg_store [MAX_NEGATIVES*FEATURES];
   logic [63:0] pool;
   int unsigned alpha_cur;
   int unsigned sel_count;
   int unsigned alpha_reg;

   selection_type expected_selections[$];
   int err_count = 0;
   int stall_cycles = 0;
   int rounds_seen = 0;
   int found_seen = 0;
   int pos_rows = 0;
   int neg_rows = 0;
   bit gaps_on = 1'b1;

   weak_classifier_selection_round uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_opcode(req_opcode), .req_sample_index(req_sample_index),
      .req_feature_index(req_feature_index), .req_feature_value(req_feature_value),
      .req_positive_count(req_positive_count), .req_negative_count(req_negative_count),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .rsp_valid(rsp_valid), .rsp_found(rsp_found),
      .rsp_chosen_feature(rsp_chosen_feature),
      .rsp_chosen_threshold(rsp_chosen_threshold),
      .rsp_polarity_positive(rsp_polarity_positive),
      .rsp_false_pass_count(rsp_false_pass_count),
      .rsp_alpha_now(rsp_alpha_now), .rsp_selected_total(rsp_selected_total)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic report(input string what, input longint got, input longint want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      err_count++;
   endtask

   // mean of one feature over the first count samples, truncated toward zero
   function automatic longint feature_mean(input bit neg, input int count, input int f);
      longint sum;
      sum = 0;
      if (count == 0) return 0;
      for (int s = 0; s < count; s++)
         sum += neg ? longint'($signed(neg_store[s*FEATURES+f]))
                    : longint'($signed(pos_store[s*FEATURES+f]));
      return sum / count;
   endfunction

   function automatic int pass_count(input bit neg, input int count, input int f,
                                     input longint thr, input bit pol);
      longint v;
      int n;
      n = 0;
      for (int s = 0; s < count; s++) begin
         v = neg ? longint'($signed(neg_store[s*FEATURES+f]))
                 : longint'($signed(pos_store[s*FEATURES+f]));
         if (pol ? (v > thr) : (v < thr)) n++;
      end
      return n;
   endfunction

   // update the predicted state for one accepted request
   task automatic predict_request(input logic [1:0] op, input int si, input int fi,
                                  input logic [31:0] val, input int pc, input int nc);
      selection_type sel;
      longint pm, nm, thr, best_thr;
      bit pol, best_pol, hit;
      int best_f, best_neg, npass;
      case (op)
         OP_WR_POS: begin
            if (si < MAX_POSITIVES) pos_store[si*FEATURES+fi] = val;
         end
         OP_WR_NEG: begin
            neg_store[si*FEATURES+fi] = val;
         end
         OP_RESTART: begin
            pool = '1;
            alpha_cur = (alpha_reg > ALPHA_SCALE) ? ALPHA_SCALE : alpha_reg;
            sel_count = 0;
         end
         default: begin
            if (pc > MAX_POSITIVES) pc = MAX_POSITIVES;
            if (nc > MAX_NEGATIVES) nc = MAX_NEGATIVES;
            hit = 0; best_f = 0; best_neg = 0; best_thr = 0; best_pol = 0;
            for (int f = 0; f < FEATURES; f++) begin
               if (pool[f]) begin
                  pm = feature_mean(0, pc, f);
                  nm = feature_mean(1, nc, f);
                  thr = (longint'(ALPHA_SCALE - alpha_cur) * nm + longint'(alpha_cur) * pm)
                        / 10;
                  pol = pm > nm;
                  if (pass_count(0, pc, f, thr, pol) == pc) begin
                     npass = pass_count(1, nc, f, thr, pol);
                     if (!hit || npass < best_neg) begin
                        hit = 1; best_f = f; best_neg = npass;
                        best_thr = thr; best_pol = pol;
                     end
                  end
               end
            end
            if (hit) begin
               pool[best_f] = 1'b0;
               if (sel_count < 127) sel_count++;
            end else if (alpha_cur > 0) begin
               alpha_cur--;
            end
            sel.found = hit;
            sel.feature = hit ? best_f[FEAT_W-1:0] : '0;
            sel.threshold = hit ? best_thr[31:0] : '0;
            sel.polarity = hit && best_pol;
            sel.false_pass = hit ? best_neg[NCNT_W-1:0] : '0;
            sel.alpha = alpha_cur[ALPHA_W-1:0];
            sel.total = sel_count[PCNT_W-1:0];
            expected_selections.insert(expected_selections.size(), sel);
         end
      endcase
   endtask

   // send one request and wait for it to be taken; start stays high for the next one
   task automatic send_request(input logic [1:0] op, input int si, input int fi,
                               input logic [31:0] val, input int pc, input int nc);
      bit taken;
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      start <= 1'b1;
      req_opcode <= op;
      req_sample_index <= si[7:0];
      req_feature_index <= fi[FEAT_W-1:0];
      req_feature_value <= val;
      req_positive_count <= pc[PCNT_W-1:0];
      req_negative_count <= nc[NCNT_W-1:0];
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      predict_request(op, si, fi, val, pc, nc);
   endtask

   // all rounds answered, then let the block settle
   task automatic wait_idle();
      start <= 1'b0;
      while (expected_selections.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_alpha(input int value);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value[ALPHA_W-1:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      alpha_reg = value;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(0, 8) - 4;
         default: return $urandom;
      endcase
   endfunction

   // zero positives and zero negatives: every pooled feature passes
   task automatic test_empty_counts();
      send_request(OP_ROUND, 0, 0, 0, 0, 0);
      send_request(OP_ROUND, 0, 0, 0, 0, 0);
      send_request(OP_RESTART, 0, 0, 0, 0, 0);
   endtask

   // fill whole sample rows so rounds only read written entries
   task automatic test_fill_rows(input int rows);
      for (int r = 0; r < rows; r++)
         for (int f = 0; f < FEATURES; f++) begin
            send_request(OP_WR_POS, r, f, pick_value(), 0, 0);
            send_request(OP_WR_NEG, r, f, pick_value(), 0, 0);
         end
      pos_rows = rows;
      neg_rows = rows;
   endtask

   // extremes, ignored writes, zero negatives and small rounds
   task automatic test_directed_rounds();
      send_request(OP_WR_POS, 0, 63, 32'h7fff_ffff, 0, 0);
      send_request(OP_WR_NEG, 0, 63, 32'h8000_0000, 0, 0);
      send_request(OP_WR_POS, 1, 0, 32'h8000_0000, 0, 0);
      send_request(OP_WR_NEG, 1, 0, 32'h7fff_ffff, 0, 0);
      send_request(OP_WR_POS, 255, 5, 32'h1234_5678, 0, 0);
      send_request(OP_WR_POS, 64, 5, 32'hdead_beef, 0, 0);
      send_request(OP_WR_NEG, 255, 63, 32'h0001_0000, 0, 0);
      send_request(OP_ROUND, 0, 0, 0, 1, 0);
      send_request(OP_ROUND, 0, 0, 0, 2, 2);
      send_request(OP_ROUND, 0, 0, 0, 0, 2);
      send_request(OP_ROUND, 0, 0, 0, 1, 1);
   endtask

   // alpha register extremes, each taking effect at restart
   task automatic test_alpha_settings();
      write_alpha(15);
      send_request(OP_ROUND, 0, 0, 0, 2, 1);
      send_request(OP_RESTART, 0, 0, 0, 0, 0);
      send_request(OP_ROUND, 0, 0, 0, 2, 2);
      write_alpha(0);
      send_request(OP_RESTART, 0, 0, 0, 0, 0);
      send_request(OP_ROUND, 0, 0, 0, 2, 2);
      write_alpha(10);
      send_request(OP_RESTART, 0, 0, 0, 0, 0);
      send_request(OP_ROUND, 0, 0, 0, 1, 2);
   endtask

   // drain the whole pool, then alpha steps down to zero and stays there
   task automatic test_pool_exhaust();
      write_alpha(3);
      send_request(OP_RESTART, 0, 0, 0, 0, 0);
      for (int i = 0; i < FEATURES + 6; i++) send_request(OP_ROUND, 0, 0, 0, 0, 0);
      send_request(OP_RESTART, 0, 0, 0, 0, 0);
   endtask

   task automatic test_random_mix(input int count);
      int pick;
      for (int i = 0; i < count; i++) begin
         if (i == count - 60) gaps_on = 1'b0;
         pick = $urandom_range(0, 99);
         if (pick < 40)
            send_request(OP_WR_POS, $urandom_range(0, 255), $urandom_range(0, 63),
                         pick_value(), $urandom_range(0, 127), $urandom_range(0, 511));
         else if (pick < 80)
            send_request(OP_WR_NEG, $urandom_range(0, 255), $urandom_range(0, 63),
                         pick_value(), $urandom_range(0, 127), $urandom_range(0, 511));
         else if (pick < 93)
            send_request(OP_ROUND, $urandom_range(0, 255), $urandom_range(0, 63), $urandom,
                         $urandom_range(0, pos_rows), $urandom_range(0, neg_rows));
         else
            send_request(OP_RESTART, $urandom_range(0, 255), $urandom_range(0, 63),
                         $urandom, $urandom_range(0, 127), $urandom_range(0, 511));
      end
   endtask

   // compare each result with the oldest prediction
   always @(negedge clock) begin
      selection_type want;
      if (!reset && rsp_valid) begin
         rounds_seen++;
         if (expected_selections.size() == 0) begin
            report("unexpected result", rsp_chosen_feature, 0);
         end else begin
            want = expected_selections.pop_front();
            if (want.found) found_seen++;
            if (rsp_found !== want.found) report("found", rsp_found, want.found);
            if (rsp_chosen_feature !== want.feature)
               report("chosen_feature", rsp_chosen_feature, want.feature);
            if (rsp_chosen_threshold !== want.threshold)
               report("chosen_threshold", rsp_chosen_threshold, want.threshold);
            if (rsp_polarity_positive !== want.polarity)
               report("polarity_positive", rsp_polarity_positive, want.polarity);
            if (rsp_false_pass_count !== want.false_pass)
               report("false_pass_count", rsp_false_pass_count, want.false_pass);
            if (rsp_alpha_now !== want.alpha) report("alpha_now", rsp_alpha_now, want.alpha);
            if (rsp_selected_total !== want.total)
               report("selected_total", rsp_selected_total, want.total);
         end
      end
   end

   // watchdog on cycles with no request or result moving
   always @(negedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d idle cycles", stall_cycles);
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      pool = '1;
      alpha_cur = ALPHA_RESET;
      alpha_reg = ALPHA_RESET;
      sel_count = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_counts();
      test_fill_rows(2);
      test_directed_rounds();
      test_alpha_settings();
      test_pool_exhaust();
      write_alpha(5);
      send_request(OP_RESTART, 0, 0, 0, 0, 0);
      test_random_mix(420);
      wait_idle();
      $display("covered %0d rounds, %0d with a selection, pool exhaustion and alpha range",
               rounds_seen, found_seen);
      if (err_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("%0d mismatches", err_count);
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
`default_nettype wire

### filelist.f
+incdir+hdl
hdl/wcsr_pkg.sv
hdl/wcsr_ram.sv
hdl/wcsr_div.sv
hdl/wcsr_ctrl.sv
hdl/wcsr_dp.sv
hdl/weak_classifier_selection_round.sv
tb/sv/tb_weak_classifier_selection_round.sv
